// ===== sv/tps_pkg.sv =====
package tps_pkg;

   // fixed field widths
   localparam int AXES       = 4;
   localparam int RANK_W     = 3;
   localparam int DIM_W      = 13;
   localparam int ORDER_W    = 8;
   localparam int WORD_W     = 64;
   localparam int DEST_W     = 12;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 13;
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 144;

   // parameter defaults
   localparam int DEF_MAX_RANK  = 4;
   localparam int DEF_MAX_ELEMS = 4096;
   localparam int QUEUE_DEPTH   = 4;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_RANK  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_DIM0  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_DIM1  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_DIM2  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_DIM3  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_ORDER = 3'd5;

   // register reset values
   localparam logic [RANK_W-1:0]  RANK_RESET  = 3'd1;
   localparam logic [DIM_W-1:0]   DIM_RESET   = 13'd1;
   localparam logic [ORDER_W-1:0] ORDER_RESET = 8'd228;

   typedef struct packed {
      logic [DEST_W-1:0] dest_index;
      logic [WORD_W-1:0] out_re;
      logic [WORD_W-1:0] out_im;
      logic              tensor_end;
      logic              config_error;
   } entry_type;

   typedef struct packed {
      logic ready;
      logic err;
   } setup_flags_type;

endpackage

// ===== sv/tps_setup.sv =====
module tps_setup #(
   parameter int LANES     = tps_pkg::AXES,
   parameter int MAX_ELEMS = tps_pkg::DEF_MAX_ELEMS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [tps_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [tps_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                            clear,
   output tps_pkg::setup_flags_type        flags,
   output logic [$clog2(MAX_ELEMS)-1:0]    size_m1,
   output logic [$clog2(MAX_ELEMS)-1:0]    lim   [LANES],
   output logic [$clog2(MAX_ELEMS)-1:0]    delta [LANES],
   output logic                            used  [LANES]
);

   localparam int IW = $clog2(MAX_ELEMS);
   localparam int PW = $clog2(MAX_ELEMS + 2);
   localparam int MW = PW + tps_pkg::DIM_W;
   localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
   localparam logic [PW-1:0] SAT = PW'(MAX_ELEMS + 1);

   localparam logic [1:0] PH_STRIDE = 2'd0;
   localparam logic [1:0] PH_DELTA  = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   logic [tps_pkg::RANK_W-1:0]  rank_ff;
   logic [tps_pkg::DIM_W-1:0]   dim_ff [LANES];
   logic [tps_pkg::ORDER_W-1:0] order_ff;

   logic [1:0]    phase_ff;
   logic [LW-1:0] step_ff;
   logic [PW-1:0] stride_ff;
   logic [IW-1:0] acc_ff;
   logic [PW-1:0] dstr_ff  [LANES];
   logic [IW-1:0] delta_ff [LANES];
   logic          err_ff;
   logic [IW-1:0] size_m1_ff;

   logic                      wr_hit;
   logic                      step_used;
   logic [1:0]                cur_ax;
   logic                      ax_ok;
   logic [LW-1:0]             ax_lane;
   logic [tps_pkg::DIM_W-1:0] ax_dim;
   logic [MW-1:0]             prod;
   logic [PW-1:0]             stride_in;
   logic [IW-1:0]             wrap;
   logic                      st_err;

   assign wr_hit = csr_we && (csr_addr <= tps_pkg::REG_ORDER);
   assign clear  = wr_hit;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff  <= tps_pkg::RANK_RESET;
         order_ff <= tps_pkg::ORDER_RESET;
         for (int j = 0; j < LANES; j++) dim_ff[j] <= tps_pkg::DIM_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            tps_pkg::REG_RANK: rank_ff <= csr_wdata[tps_pkg::RANK_W-1:0];
            tps_pkg::REG_DIM0, tps_pkg::REG_DIM1,
            tps_pkg::REG_DIM2, tps_pkg::REG_DIM3: begin
               for (int j = 0; j < LANES; j++) begin
                  if (csr_addr == tps_pkg::REG_DIM0 + tps_pkg::CSR_ADDR_W'(j))
                     dim_ff[j] <= csr_wdata;
               end
            end
            tps_pkg::REG_ORDER: order_ff <= csr_wdata[tps_pkg::ORDER_W-1:0];
            default: ;
         endcase
      end
   end

   // one step of the stride and delta passes
   always_comb begin
      step_used = (int'(step_ff) < int'(rank_ff));
      cur_ax    = order_ff[2*step_ff +: 2];
      ax_ok     = (int'(cur_ax) < LANES);
      ax_lane   = LW'(cur_ax);
      ax_dim    = ax_ok ? dim_ff[ax_lane] : tps_pkg::DIM_RESET;
      prod      = MW'(stride_ff) * MW'(ax_dim);
      stride_in = (prod > MW'(SAT)) ? SAT : PW'(prod);
      wrap      = IW'((MW'(dim_ff[step_ff]) - MW'(1)) * MW'(dstr_ff[step_ff]));
   end

   // rank, zero size and permutation checks
   always_comb begin
      logic [1:0] a;
      st_err = (rank_ff == '0) || (int'(rank_ff) > LANES);
      for (int j = 0; j < LANES; j++) begin
         a = order_ff[2*j +: 2];
         if (j < int'(rank_ff)) begin
            if (dim_ff[j] == '0) st_err = 1'b1;
            if (int'(a) >= int'(rank_ff)) st_err = 1'b1;
            for (int i = 0; i < j; i++) begin
               if (order_ff[2*i +: 2] == a) st_err = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || wr_hit) begin
         phase_ff  <= PH_STRIDE;
         step_ff   <= LW'(LANES - 1);
         stride_ff <= PW'(1);
         acc_ff    <= '0;
      end else begin
         case (phase_ff)
            PH_STRIDE: begin
               if (step_used) begin
                  stride_ff <= stride_in;
                  if (ax_ok) dstr_ff[ax_lane] <= stride_ff;
               end
               if (step_ff == '0) begin
                  phase_ff <= PH_DELTA;
                  step_ff  <= LW'(LANES - 1);
               end else begin
                  step_ff <= step_ff - LW'(1);
               end
            end
            PH_DELTA: begin
               if (step_used) begin
                  delta_ff[step_ff] <= IW'(dstr_ff[step_ff]) - acc_ff;
                  acc_ff            <= acc_ff + wrap;
               end
               if (step_ff == '0) begin
                  phase_ff   <= PH_DONE;
                  err_ff     <= st_err || (stride_ff > PW'(MAX_ELEMS));
                  size_m1_ff <= IW'(stride_ff - PW'(1));
               end else begin
                  step_ff <= step_ff - LW'(1);
               end
            end
            PH_DONE: ;
            default: phase_ff <= PH_DONE;
         endcase
      end
   end

   always_comb begin
      flags.ready = (phase_ff == PH_DONE);
      flags.err   = err_ff;
      size_m1     = size_m1_ff;
      for (int j = 0; j < LANES; j++) begin
         lim[j]   = IW'(dim_ff[j] - tps_pkg::DIM_W'(1));
         delta[j] = delta_ff[j];
         used[j]  = (j < int'(rank_ff));
      end
   end

endmodule

// ===== sv/tps_front.sv =====
module tps_front #(
   parameter int LANES     = tps_pkg::AXES,
   parameter int MAX_ELEMS = tps_pkg::DEF_MAX_ELEMS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            clear,
   input  tps_pkg::setup_flags_type        flags,
   input  logic [$clog2(MAX_ELEMS)-1:0]    size_m1,
   input  logic [$clog2(MAX_ELEMS)-1:0]    lim   [LANES],
   input  logic [$clog2(MAX_ELEMS)-1:0]    delta [LANES],
   input  logic                            used  [LANES],
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tps_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            q_full,
   output logic                            push,
   output tps_pkg::entry_type              entry
);

   localparam int IW = $clog2(MAX_ELEMS);
   localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

   logic [IW-1:0] coord_ff [LANES];
   logic [IW-1:0] count_ff;
   logic [IW-1:0] dest_ff;

   logic          last;
   logic [LW-1:0] carry;

   assign req_tready = flags.ready && !q_full;
   assign push       = req_tvalid && req_tready;
   assign last       = (count_ff == size_m1);

   // innermost used lane that has not reached its limit takes the increment
   always_comb begin
      carry = '0;
      for (int j = 0; j < LANES; j++) begin
         if (used[j] && (coord_ff[j] != lim[j])) carry = LW'(j);
      end
   end

   always_comb begin
      entry.out_re = req_tdata[tps_pkg::WORD_W-1:0];
      entry.out_im = req_tdata[2*tps_pkg::WORD_W-1:tps_pkg::WORD_W];
      if (flags.err) begin
         entry.dest_index   = '0;
         entry.tensor_end   = 1'b0;
         entry.config_error = 1'b1;
      end else begin
         entry.dest_index   = tps_pkg::DEST_W'(dest_ff);
         entry.tensor_end   = last;
         entry.config_error = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int j = 0; j < LANES; j++) coord_ff[j] <= '0;
         count_ff <= '0;
         dest_ff  <= '0;
      end else if (push) begin
         if (flags.err || last) begin
            for (int j = 0; j < LANES; j++) coord_ff[j] <= '0;
            count_ff <= '0;
            dest_ff  <= '0;
         end else begin
            for (int j = 0; j < LANES; j++) begin
               if (j == int'(carry)) coord_ff[j] <= coord_ff[j] + IW'(1);
               else if (j > int'(carry)) coord_ff[j] <= '0;
            end
            count_ff <= count_ff + IW'(1);
            dest_ff  <= dest_ff + delta[carry];
         end
      end
   end

endmodule

// ===== sv/tps_queue.sv =====
module tps_queue #(
   parameter int DEPTH = tps_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tps_pkg::entry_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output tps_pkg::entry_type head
);

   localparam int QW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   tps_pkg::entry_type slot_ff [DEPTH];
   logic [QW-1:0] wr_ff;
   logic [QW-1:0] rd_ff;
   logic [CW-1:0] count_ff;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == QW'(DEPTH - 1)) ? '0 : wr_ff + QW'(1);
         if (pop)  rd_ff <= (rd_ff == QW'(DEPTH - 1)) ? '0 : rd_ff + QW'(1);
         if (push && !pop)      count_ff <= count_ff + CW'(1);
         else if (pop && !push) count_ff <= count_ff - CW'(1);
      end
   end

endmodule

// ===== sv/tps_back.sv =====
module tps_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  tps_pkg::entry_type              head,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tps_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   output logic                            rsp_tuser
);

   localparam int PAD_W = tps_pkg::RSP_DATA_W - tps_pkg::DEST_W - 2*tps_pkg::WORD_W;

   logic               valid_ff;
   tps_pkg::entry_type out_ff;

   assign pop = q_valid && (!valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (pop) valid_ff <= 1'b1;
      else if (rsp_tready) valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (pop) out_ff <= head;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_ff.out_im, out_ff.out_re, out_ff.dest_index};
   assign rsp_tlast  = out_ff.tensor_end;
   assign rsp_tuser  = out_ff.config_error;

endmodule

// ===== sv/tensor_axis_permute_scatter_core.sv =====
// channel  | dir | handshake               | payload
// req      | in  | req_tvalid / req_tready | tdata: value_re, value_im
// rsp      | out | rsp_tvalid / rsp_tready | tdata: dest_index, out_re, out_im;
//          |     |                         | tlast: tensor_end; tuser: config_error
// csr      | in  | csr_we                  | csr_addr, csr_wdata
//
// one beat per cycle sustained while setup is done and rsp_tready stays high; an accepted req
// is registered in the queue and then in the rsp stage before rsp_tvalid; after reset and
// after every register write a setup pass (one stride step and one delta step per axis) holds req_tready low
// reset is synchronous active high and clears position, queue and output
// a stalled rsp fills the queue; req_tready drops only once the queue is full
module tensor_axis_permute_scatter_core #(
   parameter int MAX_RANK  = tps_pkg::DEF_MAX_RANK,
   parameter int MAX_ELEMS = tps_pkg::DEF_MAX_ELEMS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tps_pkg::REQ_DATA_W-1:0]  req_tdata,   // value_re, value_im
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tps_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // dest_index, out_re, out_im
   output logic                            rsp_tlast,   // tensor_end
   output logic                            rsp_tuser,   // config_error
   input  logic                            csr_we,
   input  logic [tps_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [tps_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // coordinate lanes actually built
   localparam int LANES = (MAX_RANK < tps_pkg::AXES) ? MAX_RANK : tps_pkg::AXES;
   localparam int IW    = $clog2(MAX_ELEMS);

   logic                     clear;
   tps_pkg::setup_flags_type flags;
   logic [IW-1:0]            size_m1;
   logic [IW-1:0]            lim   [LANES];
   logic [IW-1:0]            delta [LANES];
   logic                     used  [LANES];

   logic               push;
   tps_pkg::entry_type entry;
   logic               q_full;
   logic               q_valid;
   tps_pkg::entry_type head;
   logic               pop;

   // registers plus derived per-axis step deltas for the incremental index
   tps_setup #(
      .LANES     (LANES),
      .MAX_ELEMS (MAX_ELEMS)
   ) u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .clear     (clear),
      .flags     (flags),
      .size_m1   (size_m1),
      .lim       (lim),
      .delta     (delta),
      .used      (used)
   );

   // front: mixed-radix counter and destination index, one add per beat
   tps_front #(
      .LANES     (LANES),
      .MAX_ELEMS (MAX_ELEMS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .clear      (clear),
      .flags      (flags),
      .size_m1    (size_m1),
      .lim        (lim),
      .delta      (delta),
      .used       (used),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .entry      (entry)
   );

   // short queue decoupling the two sides
   tps_queue #(
      .DEPTH (tps_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (entry),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (head)
   );

   // back: registered rsp stage
   tps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== sv/tps_checker.sv =====
module tps_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tps_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            rsp_tuser,
   input logic                            csr_we,
   input logic [tps_pkg::CSR_ADDR_W-1:0]  csr_addr
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // error beats carry a zero index and never close a tensor
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[tps_pkg::DEST_W-1:0] == '0 && !rsp_tlast)
      else $error("config error beat with index or tlast");

   // a register write restarts setup, so no beat is taken right after
   a_csr_stall: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_addr <= tps_pkg::REG_ORDER) |=> !req_tready)
      else $error("req accepted during setup");

   // nothing leaves right out of reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

endmodule

bind tensor_axis_permute_scatter_core tps_checker u_checker (.*);
